// ===== hdl/fss_pkg.sv =====
package fss_pkg;

  localparam int QUERY_MAX = 48;
  localparam int HAY_MAX   = 256;
  localparam int QWORDS    = QUERY_MAX / 8;

  localparam int CHAR_W  = 8;
  localparam int QIDX_W  = 6;
  localparam int SCORE_W = 12;
  localparam int PTS_W   = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [PTS_W-1:0]   PTS_BASE  = 8'd4;
  localparam logic [PTS_W-1:0]   PTS_RUN   = 8'd6;
  localparam logic [PTS_W-1:0]   PTS_START = 8'd12;
  localparam logic [PTS_W-1:0]   PTS_WORD  = 8'd8;
  localparam logic [CHAR_W-1:0]  CASE_OFFSET = 8'd32;
  localparam logic [SCORE_W-1:0] SCORE_MAX = 12'd4095;
  localparam logic [7:0]         GAP_MAX   = 8'd255;
  localparam logic [7:0]         POS_MAX   = 8'(HAY_MAX - 1);
  localparam logic [QIDX_W-1:0]  QLEN_MAX  = 6'(QUERY_MAX);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_0_7   = 3'd0,
    REG_QUERY_8_15  = 3'd1,
    REG_QUERY_16_23 = 3'd2,
    REG_QUERY_24_31 = 3'd3,
    REG_QUERY_32_39 = 3'd4,
    REG_QUERY_40_47 = 3'd5,
    REG_QUERY_LEN   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] q_char;
    logic [QIDX_W-1:0] q_len;
  } fss_query_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               matched;
  } fss_result_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic is_separator(input logic [CHAR_W-1:0] c);
    return (c == 8'h20) || (c == 8'h2F) || (c == 8'h5F) || (c == 8'h2D);
  endfunction

endpackage

// ===== hdl/fss_query.sv =====
module fss_query (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic [fss_pkg::QIDX_W-1:0]     q_index,
  output fss_pkg::fss_query_t            query
);
  import fss_pkg::*;

  logic [QWORDS-1:0][63:0]        words_r;
  logic [QIDX_W-1:0]              len_r;
  logic [QUERY_MAX-1:0][CHAR_W-1:0] bytes_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_r <= '0;
      len_r   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_QUERY_LEN) begin
        len_r <= cfg_data[QIDX_W-1:0];
      end else if (cfg_index <= REG_QUERY_40_47) begin
        words_r[cfg_index] <= cfg_data;
      end
    end
  end

  assign bytes_w      = words_r;
  assign query.q_char = bytes_w[q_index];
  // clamp oversized lengths
  assign query.q_len  = (len_r > QLEN_MAX) ? QLEN_MAX : len_r;

endmodule

// ===== hdl/fss_score.sv =====
module fss_score (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [fss_pkg::CHAR_W-1:0]  hay_char,
  input  logic                        is_last,
  input  fss_pkg::fss_query_t         query,
  output logic [fss_pkg::QIDX_W-1:0]  q_index,
  output fss_pkg::fss_result_t        result
);
  import fss_pkg::*;

  logic [QIDX_W-1:0]  qidx_r, qidx_nxt;
  logic [QIDX_W-1:0]  run_r, run_nxt, run_inc;
  logic               any_r, any_nxt;
  logic               lastm_r, lastm_nxt;
  logic [7:0]         gap_r, gap_nxt;
  logic [7:0]         pos_r, pos_nxt;
  logic [CHAR_W-1:0]  prev_r, prev_nxt;
  logic [SCORE_W-1:0] score_r, score_nxt;

  logic               hit;
  logic [PTS_W-1:0]   pts, net;
  logic [SCORE_W:0]   sum;

  assign q_index = qidx_r;
  assign hit = (qidx_r < query.q_len) && (hay_char != '0) &&
               (fold_case(hay_char) == fold_case(query.q_char));
  assign run_inc = run_r + 1'b1;

  always_comb begin
    pts = PTS_BASE;
    if (lastm_r) begin
      pts = pts + PTS_RUN + {1'b0, run_inc, 1'b0};
    end
    if (pos_r == '0) begin
      pts = pts + PTS_START;
    end else if (is_separator(prev_r)) begin
      pts = pts + PTS_WORD;
    end
    net = (pts > gap_r) ? pts - gap_r : '0;
    if (net == '0) begin
      net = 8'd1;
    end
    sum = {1'b0, score_r} + (SCORE_W+1)'(net);
  end

  always_comb begin
    qidx_nxt  = qidx_r;
    run_nxt   = run_r;
    any_nxt   = any_r;
    lastm_nxt = 1'b0;
    gap_nxt   = (gap_r < GAP_MAX) ? gap_r + 1'b1 : gap_r;
    score_nxt = score_r;
    if (hit) begin
      run_nxt   = lastm_r ? run_inc : '0;
      score_nxt = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
      qidx_nxt  = qidx_r + 1'b1;
      any_nxt   = 1'b1;
      lastm_nxt = 1'b1;
      gap_nxt   = '0;
    end
    pos_nxt  = (pos_r < POS_MAX) ? pos_r + 1'b1 : pos_r;
    prev_nxt = hay_char;

    if (query.q_len == '0) begin
      result.score   = SCORE_W'(1);
      result.matched = 1'b1;
    end else if (qidx_nxt >= query.q_len) begin
      result.score   = score_nxt;
      result.matched = 1'b1;
    end else begin
      result.score   = '0;
      result.matched = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && is_last)) begin
      qidx_r  <= '0;
      run_r   <= '0;
      any_r   <= 1'b0;
      lastm_r <= 1'b0;
      gap_r   <= '0;
      pos_r   <= '0;
      prev_r  <= '0;
      score_r <= '0;
    end else if (step) begin
      qidx_r  <= qidx_nxt;
      run_r   <= run_nxt;
      any_r   <= any_nxt;
      lastm_r <= lastm_nxt;
      gap_r   <= gap_nxt;
      pos_r   <= pos_nxt;
      prev_r  <= prev_nxt;
      score_r <= score_nxt;
    end
  end

endmodule

// ===== hdl/fuzzy_subsequence_scorer.sv =====
// Fuzzy subsequence scorer: rates one haystack string against a query.
//
// Load the query through the cfg channel while the block is idle: indexes
// 0..5 take eight query bytes each (lowest byte first), index 6 takes the
// query length; other indexes are dropped. cfg_ready is always high.
// Stream the haystack on the in_ channel, one character per item in
// in_tdata, with in_tlast on the final character. Exactly one result item
// leaves on the out_ channel per string: out_tdata carries the score,
// out_tuser the matched flag.
//
// Throughput: one character per cycle while in_tready stays high. Each item
// is held in an input register, then scored against the running state, and
// the result of the last character lands in the output register, which
// drives out_tvalid.
// A stalled receiver holds the result in the output register; the input
// side keeps taking characters until a second string ends, then the input
// register holds that last character and in_tready drops.
// Reset (rst_n low, synchronous) clears the query to empty, the per-string
// state and both pipeline registers.
module fuzzy_subsequence_scorer (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] hay_char
  input  logic        in_tlast,   // is_last
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [11:0] score, [15:12] zero
  output logic        out_tuser,  // [0] matched
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import fss_pkg::*;

  // input register
  logic              in_valid_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              in_last_r;

  // output register
  logic              out_valid_r;
  fss_result_t       out_res_r;

  logic              advance;
  logic              out_free;
  logic [QIDX_W-1:0] q_index;
  fss_query_t        query;
  fss_result_t       result;

  assign cfg_ready = 1'b1;

  // A non-last character never needs the output register; a last one
  // needs it empty or draining this cycle.
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || advance;

  fss_query u_query (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_index   (q_index),
    .query     (query)
  );

  fss_score u_score (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .hay_char (in_char_r),
    .is_last  (in_last_r),
    .query    (query),
    .q_index  (q_index),
    .result   (result)
  );

  // Hold the character until the scoring step takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Capture the result on the last character; drop valid once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.score};
  assign out_tuser  = out_res_r.matched;

endmodule
